[rtl/core/dsal_pkg.sv]
// Package for the drag scroll axis lock block: register map, reset values,
// configuration and divider structs, and the sequencer state type.
// No dependencies; used by scoped names in the CSR, divider, sequencer, top.
package dsal_pkg;

   // Configuration port geometry: eight 32-bit registers at byte address 4*i.
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   localparam logic [2:0] REG_THR_H     = 3'd0;
   localparam logic [2:0] REG_THR_V     = 3'd1;
   localparam logic [2:0] REG_DIV_H     = 3'd2;
   localparam logic [2:0] REG_DIV_V     = 3'd3;
   localparam logic [2:0] REG_START     = 3'd4;
   localparam logic [2:0] REG_SUSTAIN   = 3'd5;
   localparam logic [2:0] REG_TIMEOUT   = 3'd6;
   localparam logic [2:0] REG_REVERSE   = 3'd7;

   localparam logic [15:0] RST_THR      = 16'd6;
   localparam logic [7:0]  RST_DIV      = 8'd8;
   localparam logic [3:0]  RST_RATIO    = 4'd3;
   localparam logic [15:0] RST_TIMEOUT  = 16'd40;
   localparam logic [1:0]  RST_REVERSE  = 2'd0;

   // Timing rules in milliseconds.
   localparam logic [31:0] RATE_LIMIT_MS = 32'd16;
   localparam logic [31:0] EXPIRE_MS     = 32'd100;

   localparam int DIV_STEPS = 32;

   typedef enum logic [1:0] {
      AXIS_NONE = 2'd0,
      AXIS_X    = 2'd1,
      AXIS_Y    = 2'd2
   } axis_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ADD,
      S_AGE,
      S_PROD,
      S_LOCK,
      S_START,
      S_WAIT,
      S_APPLY,
      S_DECAY,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [15:0] thr_h;
      logic [15:0] thr_v;
      logic [7:0]  div_h;
      logic [7:0]  div_v;
      logic [3:0]  start_ratio;
      logic [3:0]  sustain_ratio;
      logic [15:0] timeout;
      logic [1:0]  reverse;
   } cfg_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [7:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
      logic [7:0]  remainder;
   } div_rsp_type;

endpackage

[rtl/core/dsal_if.sv]
// Valid/ready channel interfaces for the report items and the result items.
// Depends on nothing; used by the sequencer and the top level.
interface dsal_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] dx_motion;
   logic signed [15:0] dy_motion;
   logic signed [7:0]  h_in;
   logic signed [7:0]  v_in;
   logic [31:0]        now_ms;

   modport source (output valid, dx_motion, dy_motion, h_in, v_in, now_ms, input ready);
   modport sink   (input valid, dx_motion, dy_motion, h_in, v_in, now_ms, output ready);
endinterface

interface dsal_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] h_out;
   logic signed [7:0] v_out;
   logic              scroll_emitted;

   modport source (output valid, h_out, v_out, scroll_emitted, input ready);
   modport sink   (input valid, h_out, v_out, scroll_emitted, output ready);
endinterface

[rtl/core/dsal_csr.sv]
// APB-style register file holding the eight configuration registers.
// Depends on dsal_pkg for the register map, reset values and cfg_type.
module dsal_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [dsal_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [dsal_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [dsal_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready,
   output dsal_pkg::cfg_type           cfg
);

   dsal_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0]        index;
   logic              wr_en;

   assign index      = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            dsal_pkg::REG_THR_H:   cfg_in.thr_h         = csr_pwdata[15:0];
            dsal_pkg::REG_THR_V:   cfg_in.thr_v         = csr_pwdata[15:0];
            dsal_pkg::REG_DIV_H:   cfg_in.div_h         = csr_pwdata[7:0];
            dsal_pkg::REG_DIV_V:   cfg_in.div_v         = csr_pwdata[7:0];
            dsal_pkg::REG_START:   cfg_in.start_ratio   = csr_pwdata[3:0];
            dsal_pkg::REG_SUSTAIN: cfg_in.sustain_ratio = csr_pwdata[3:0];
            dsal_pkg::REG_TIMEOUT: cfg_in.timeout       = csr_pwdata[15:0];
            dsal_pkg::REG_REVERSE: cfg_in.reverse       = csr_pwdata[1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         dsal_pkg::REG_THR_H:   csr_prdata = {16'd0, cfg_ff.thr_h};
         dsal_pkg::REG_THR_V:   csr_prdata = {16'd0, cfg_ff.thr_v};
         dsal_pkg::REG_DIV_H:   csr_prdata = {24'd0, cfg_ff.div_h};
         dsal_pkg::REG_DIV_V:   csr_prdata = {24'd0, cfg_ff.div_v};
         dsal_pkg::REG_START:   csr_prdata = {28'd0, cfg_ff.start_ratio};
         dsal_pkg::REG_SUSTAIN: csr_prdata = {28'd0, cfg_ff.sustain_ratio};
         dsal_pkg::REG_TIMEOUT: csr_prdata = {16'd0, cfg_ff.timeout};
         dsal_pkg::REG_REVERSE: csr_prdata = {30'd0, cfg_ff.reverse};
         default:               csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.thr_h         <= dsal_pkg::RST_THR;
         cfg_ff.thr_v         <= dsal_pkg::RST_THR;
         cfg_ff.div_h         <= dsal_pkg::RST_DIV;
         cfg_ff.div_v         <= dsal_pkg::RST_DIV;
         cfg_ff.start_ratio   <= dsal_pkg::RST_RATIO;
         cfg_ff.sustain_ratio <= dsal_pkg::RST_RATIO;
         cfg_ff.timeout       <= dsal_pkg::RST_TIMEOUT;
         cfg_ff.reverse       <= dsal_pkg::RST_REVERSE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/core/dsal_div.sv]
// Radix-2 restoring divider: 32-bit unsigned dividend by a nonzero 8-bit
// divisor, one quotient bit per cycle. Depends on dsal_pkg for its structs.
module dsal_div (
   input  logic                  clock,
   input  logic                  reset,
   input  dsal_pkg::div_req_type div_req,
   output dsal_pkg::div_rsp_type div_rsp
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  count_ff, count_in;
   logic [7:0]  rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [7:0]  dvs_ff, dvs_in;
   logic [8:0]  partial;
   logic [8:0]  trial;

   // The next dividend bit shifts in below the running remainder.
   assign partial = {rem_ff, quo_ff[31]};
   assign trial   = partial - {1'b0, dvs_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = div_req.dividend;
         dvs_in   = div_req.divisor;
      end else if (busy_ff) begin
         if (!trial[8]) begin
            rem_in = trial[7:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = partial[7:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         count_in = count_ff + 5'd1;
         if (count_ff == 5'(dsal_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

[rtl/core/dsal_seq.sv]
// Sequencer and state of the drag scroll axis lock: accumulators, stamps,
// lock decision and step application around the shared divider.
// Depends on dsal_pkg and the channel interfaces in dsal_if.sv.
module dsal_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  dsal_pkg::cfg_type     cfg,
   dsal_req_if.sink              req,
   dsal_rsp_if.source            rsp,
   output dsal_pkg::div_req_type div_req,
   input  dsal_pkg::div_rsp_type div_rsp
);

   dsal_pkg::state_type state_ff, state_in;
   dsal_pkg::axis_type  lock_ff, lock_in;

   logic signed [15:0] dx_ff, dy_ff;
   logic signed [7:0]  h_ff, v_ff;
   logic [31:0]        now_ff;

   logic signed [31:0] accx_ff, accx_in, accy_ff, accy_in;
   logic [31:0]        lm_ff, lm_in, ls_ff, ls_in;
   logic [31:0]        ax_ff, ax_in, ay_ff, ay_in;
   logic               active_ff, active_in;
   logic [35:0]        pxs_ff, pxs_in, pxu_ff, pxu_in, pys_ff, pys_in, pyu_ff, pyu_in;
   logic               neg_ff, neg_in;
   logic signed [7:0]  hout_ff, hout_in, vout_ff, vout_in;
   logic               emit_ff, emit_in;

   logic signed [16:0] dx_wide, dy_wide, dx_ext, dy_ext;
   logic signed [32:0] sum_x, sum_y;
   logic signed [31:0] sat_x, sat_y;
   logic [31:0]        age_m, age_s;
   logic               moved;
   logic               above_x, above_y, start_x, start_y, keep_x, keep_y;
   dsal_pkg::axis_type pick;
   logic [7:0]         divisor;
   logic signed [33:0] step, base, step_sum;
   logic signed [7:0]  clamped;
   logic signed [31:0] rem_signed, half_x, half_y;

   function automatic logic [31:0] mag32(input logic signed [31:0] a);
      mag32 = a[31] ? 32'(-a) : 32'(a);
   endfunction

   function automatic logic signed [7:0] clamp8(input logic signed [33:0] x);
      if (x < -34'sd128)
         clamp8 = -8'sd128;
      else if (x > 34'sd127)
         clamp8 = 8'sd127;
      else
         clamp8 = x[7:0];
   endfunction

   // Halving truncates toward zero, so a negative value is nudged up first.
   function automatic logic signed [31:0] halve(input logic signed [31:0] a);
      logic signed [31:0] t;
      t = a + {31'd0, a[31]};
      halve = t >>> 1;
   endfunction

   // Motion with optional sign reversal, then a saturating add.
   assign dx_wide = {dx_ff[15], dx_ff};
   assign dy_wide = {dy_ff[15], dy_ff};
   assign dx_ext  = cfg.reverse[0] ? -dx_wide : dx_wide;
   assign dy_ext  = cfg.reverse[1] ? -dy_wide : dy_wide;
   assign sum_x   = {accx_ff[31], accx_ff} + {{16{dx_ext[16]}}, dx_ext};
   assign sum_y   = {accy_ff[31], accy_ff} + {{16{dy_ext[16]}}, dy_ext};
   assign sat_x   = (sum_x[32] != sum_x[31]) ?
                    (sum_x[32] ? 32'sh8000_0000 : 32'sh7fff_ffff) : sum_x[31:0];
   assign sat_y   = (sum_y[32] != sum_y[31]) ?
                    (sum_y[32] ? 32'sh8000_0000 : 32'sh7fff_ffff) : sum_y[31:0];
   assign moved   = (dx_ff != 16'sd0) || (dy_ff != 16'sd0);

   assign age_m = now_ff - lm_ff;
   assign age_s = now_ff - ls_ff;

   assign above_x = ax_ff >= {16'd0, cfg.thr_h};
   assign above_y = ay_ff >= {16'd0, cfg.thr_v};
   assign start_x = above_x && ({4'd0, ax_ff} >= pys_ff);
   assign start_y = above_y && ({4'd0, ay_ff} >= pxs_ff);
   assign keep_x  = above_x && ({4'd0, ax_ff} >= pyu_ff);
   assign keep_y  = above_y && ({4'd0, ay_ff} >= pxu_ff);
   assign pick    = (start_x == start_y) ? dsal_pkg::AXIS_NONE :
                    (start_x ? dsal_pkg::AXIS_X : dsal_pkg::AXIS_Y);

   assign divisor = (lock_ff == dsal_pkg::AXIS_X) ?
                    ((cfg.div_h == 8'd0) ? 8'd1 : cfg.div_h) :
                    ((cfg.div_v == 8'd0) ? 8'd1 : cfg.div_v);

   assign step       = neg_ff ? -$signed({2'b00, div_rsp.quotient}) :
                                 $signed({2'b00, div_rsp.quotient});
   assign base       = (lock_ff == dsal_pkg::AXIS_X) ? 34'(h_ff) : 34'(v_ff);
   assign step_sum   = base + step;
   assign clamped    = clamp8(step_sum);
   assign rem_signed = neg_ff ? -$signed({24'd0, div_rsp.remainder}) :
                                 $signed({24'd0, div_rsp.remainder});
   assign half_x     = halve(accx_ff);
   assign half_y     = halve(accy_ff);

   always_comb begin
      state_in  = state_ff;
      lock_in   = lock_ff;
      accx_in   = accx_ff;
      accy_in   = accy_ff;
      lm_in     = lm_ff;
      ls_in     = ls_ff;
      ax_in     = ax_ff;
      ay_in     = ay_ff;
      active_in = active_ff;
      pxs_in    = pxs_ff;
      pxu_in    = pxu_ff;
      pys_in    = pys_ff;
      pyu_in    = pyu_ff;
      neg_in    = neg_ff;
      hout_in   = hout_ff;
      vout_in   = vout_ff;
      emit_in   = emit_ff;
      div_req.start    = 1'b0;
      div_req.dividend = (lock_ff == dsal_pkg::AXIS_X) ? ax_ff : ay_ff;
      div_req.divisor  = divisor;

      case (state_ff)
         dsal_pkg::S_IDLE: begin
            if (req.valid) state_in = dsal_pkg::S_ADD;
         end
         dsal_pkg::S_ADD: begin
            if (moved) begin
               accx_in = sat_x;
               accy_in = sat_y;
               lm_in   = now_ff;
            end
            hout_in  = h_ff;
            vout_in  = v_ff;
            emit_in  = 1'b0;
            state_in = dsal_pkg::S_AGE;
         end
         dsal_pkg::S_AGE: begin
            ax_in     = mag32(accx_ff);
            ay_in     = mag32(accy_ff);
            active_in = moved || (age_m <= {16'd0, cfg.timeout});
            if (((accx_ff != 32'sd0) || (accy_ff != 32'sd0)) && (age_m > dsal_pkg::EXPIRE_MS)) begin
               // Stale gesture: drop everything accumulated so far.
               lock_in  = dsal_pkg::AXIS_NONE;
               accx_in  = '0;
               accy_in  = '0;
               state_in = dsal_pkg::S_DONE;
            end else if (age_s >= dsal_pkg::RATE_LIMIT_MS) begin
               state_in = dsal_pkg::S_PROD;
            end else begin
               state_in = dsal_pkg::S_DONE;
            end
         end
         dsal_pkg::S_PROD: begin
            pxs_in   = {4'd0, ax_ff} * {32'd0, cfg.start_ratio};
            pxu_in   = {4'd0, ax_ff} * {32'd0, cfg.sustain_ratio};
            pys_in   = {4'd0, ay_ff} * {32'd0, cfg.start_ratio};
            pyu_in   = {4'd0, ay_ff} * {32'd0, cfg.sustain_ratio};
            state_in = dsal_pkg::S_LOCK;
         end
         dsal_pkg::S_LOCK: begin
            state_in = dsal_pkg::S_DONE;
            case (lock_ff)
               dsal_pkg::AXIS_NONE: begin
                  if (active_ff) begin
                     lock_in = pick;
                     if (pick != dsal_pkg::AXIS_NONE) state_in = dsal_pkg::S_START;
                  end
               end
               dsal_pkg::AXIS_X: begin
                  if (!active_ff) begin
                     lock_in = dsal_pkg::AXIS_NONE;
                  end else if (keep_x) begin
                     state_in = dsal_pkg::S_START;
                  end else if (!above_x && !above_y) begin
                     lock_in = dsal_pkg::AXIS_NONE;
                  end else begin
                     // A wobbling lock is kept unless the other axis can start.
                     if (start_y) lock_in = dsal_pkg::AXIS_Y;
                     state_in = dsal_pkg::S_START;
                  end
               end
               dsal_pkg::AXIS_Y: begin
                  if (!active_ff) begin
                     lock_in = dsal_pkg::AXIS_NONE;
                  end else if (keep_y) begin
                     state_in = dsal_pkg::S_START;
                  end else if (!above_x && !above_y) begin
                     lock_in = dsal_pkg::AXIS_NONE;
                  end else begin
                     if (start_x) lock_in = dsal_pkg::AXIS_X;
                     state_in = dsal_pkg::S_START;
                  end
               end
               default: lock_in = dsal_pkg::AXIS_NONE;
            endcase
         end
         dsal_pkg::S_START: begin
            div_req.start = 1'b1;
            neg_in   = (lock_ff == dsal_pkg::AXIS_X) ? accx_ff[31] : accy_ff[31];
            state_in = dsal_pkg::S_WAIT;
         end
         dsal_pkg::S_WAIT: begin
            if (div_rsp.done) state_in = dsal_pkg::S_APPLY;
         end
         dsal_pkg::S_APPLY: begin
            if (div_rsp.quotient != 32'd0) begin
               if (lock_ff == dsal_pkg::AXIS_X) begin
                  accx_in = rem_signed;
                  hout_in = clamped;
                  accy_in = half_y;
               end else begin
                  accy_in = rem_signed;
                  vout_in = clamped;
                  accx_in = half_x;
               end
               emit_in  = 1'b1;
               ls_in    = now_ff;
               state_in = dsal_pkg::S_DECAY;
            end else begin
               state_in = dsal_pkg::S_DONE;
            end
         end
         dsal_pkg::S_DECAY: begin
            // The halved axis is dropped once it falls below its threshold.
            if (lock_ff == dsal_pkg::AXIS_X) begin
               if (mag32(accy_ff) < {16'd0, cfg.thr_v}) accy_in = '0;
            end else begin
               if (mag32(accx_ff) < {16'd0, cfg.thr_h}) accx_in = '0;
            end
            state_in = dsal_pkg::S_DONE;
         end
         dsal_pkg::S_DONE: begin
            if (rsp.ready) state_in = dsal_pkg::S_IDLE;
         end
         default: state_in = dsal_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dsal_pkg::S_IDLE;
         lock_ff  <= dsal_pkg::AXIS_NONE;
         accx_ff  <= '0;
         accy_ff  <= '0;
         lm_ff    <= '0;
         ls_ff    <= '0;
      end else begin
         state_ff <= state_in;
         lock_ff  <= lock_in;
         accx_ff  <= accx_in;
         accy_ff  <= accy_in;
         lm_ff    <= lm_in;
         ls_ff    <= ls_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         dx_ff  <= req.dx_motion;
         dy_ff  <= req.dy_motion;
         h_ff   <= req.h_in;
         v_ff   <= req.v_in;
         now_ff <= req.now_ms;
      end
      ax_ff     <= ax_in;
      ay_ff     <= ay_in;
      active_ff <= active_in;
      pxs_ff    <= pxs_in;
      pxu_ff    <= pxu_in;
      pys_ff    <= pys_in;
      pyu_ff    <= pyu_in;
      neg_ff    <= neg_in;
      hout_ff   <= hout_in;
      vout_ff   <= vout_in;
      emit_ff   <= emit_in;
   end

   assign req.ready          = (state_ff == dsal_pkg::S_IDLE);
   assign rsp.valid          = (state_ff == dsal_pkg::S_DONE);
   assign rsp.h_out          = hout_ff;
   assign rsp.v_out          = vout_ff;
   assign rsp.scroll_emitted = emit_ff;

endmodule

[rtl/core/drag_scroll_axis_lock_core.sv]
// Drag scroll axis lock: turns pointer motion items into scroll steps.
// One item at a time: after acceptance an item passes the add and age states
// and ends there when the accumulators expire or a step is held back. Else it
// passes the product and lock states, and when a lock holds it goes on through
// divider start, wait and apply, then decay if the quotient is nonzero. The next
// item is accepted at the earliest in the cycle after the result is taken.
// Synchronous reset restores the register defaults and clears accumulators,
// stamps and the lock at once; there is no clearing pass.
module drag_scroll_axis_lock_core (
   input  logic                        clock,
   input  logic                        reset,
   dsal_req_if.sink                    req,
   dsal_rsp_if.source                  rsp,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [dsal_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [dsal_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [dsal_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);

   dsal_pkg::cfg_type     cfg;
   dsal_pkg::div_req_type div_req;
   dsal_pkg::div_rsp_type div_rsp;

   dsal_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dsal_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   dsal_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req     (req),
      .rsp     (rsp),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

endmodule

[rtl/core/dsal_checker.sv]
// Port-level checker for the drag scroll axis lock core, bound to the top.
// Depends only on the top level's ports.
module dsal_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   // One item in flight: no new item is taken while a result is pending.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input ready while a result is pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (!req_ready && !rsp_valid))
      else $error("block not busy after accepting an item");

   a_idle_after_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> (!rsp_valid && req_ready))
      else $error("block not idle after a result was taken");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped before it was taken");

endmodule

bind drag_scroll_axis_lock_core dsal_checker u_dsal_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready)
);
